/* rtl/affine_rotate_scan_remap_macros.svh */
// Assertion macros shared by the affine rotate-scan remapper RTL.
`ifndef AFFINE_ROTATE_SCAN_REMAP_MACROS_SVH
`define AFFINE_ROTATE_SCAN_REMAP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARSR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arsr assertion failed");

// Next-cycle implication, checked outside reset.
`define ARSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arsr assertion failed");

`endif

/* rtl/arsr_pkg.sv */
// Shared types and constants for the affine rotate-scan remapper.
package arsr_pkg;

    localparam int ACC_W      = 32;
    localparam int FRAC_BITS  = 14;
    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int PEN_W      = 16;
    localparam int OUT_PEN_W  = 13;
    localparam int PRIO_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int HOLD_W     = 2;

    localparam logic [PEN_W-1:0]  EMPTY_PEN  = 16'hFFFF;
    localparam logic [PRIO_W-1:0] EMPTY_PRIO = 8'hFF;
    // cycles for the frame-start base to settle after a register write
    localparam logic [HOLD_W-1:0] CFG_SETTLE = 2'd2;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_RENDER = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X     = 3'd0,
        REG_START_Y     = 3'd1,
        REG_ROW_STEP_X  = 3'd2,
        REG_ROW_STEP_Y  = 3'd3,
        REG_LINE_STEP_X = 3'd4,
        REG_LINE_STEP_Y = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_pos;

endpackage

/* rtl/affine_rotate_scan_remap.sv */
// Affine rotate-scan remapper: takes one item per clock, load or render, while
// not held off. After reset the frame store is swept to empty, one entry per clock,
// all 1 << (2*SRC_SIDE_BITS) entries (262144 by default); no item is taken
// meanwhile, though register writes are. A load writes one pixel; a render reads
// the store once and returns the next raster pixel, one render per clock sustained
// while the output is not stalled, limited by the single frame-store read port.
// After any register write, items are held off while the frame-start base settles.
// Up to two render results are held when the output side stalls.
module affine_rotate_scan_remap #(
    parameter int OUT_WIDTH     = 320,
    parameter int OUT_HEIGHT    = 224,
    parameter int SRC_SIDE_BITS = 9
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [arsr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arsr_pkg::ACC_W-1:0]          i_cfg_data,
    // items in
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic [8:0]                          i_src_col,
    input  logic [8:0]                          i_src_row,
    input  logic [arsr_pkg::PEN_W-1:0]          i_src_pen,
    // results out
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [arsr_pkg::COL_W-1:0]          o_out_col,
    output logic [arsr_pkg::ROW_W-1:0]          o_out_row,
    output logic [arsr_pkg::OUT_PEN_W-1:0]      o_out_pen,
    output logic [arsr_pkg::PRIO_W-1:0]         o_priority_res,
    output logic                                o_opaque,
    output logic                                o_frame_last
);

    `include "affine_rotate_scan_remap_macros.svh"

    localparam int SB     = SRC_SIDE_BITS;
    localparam int ADDR_W = 2 * SRC_SIDE_BITS;
    localparam int AW     = arsr_pkg::ACC_W;

    logic [AW-1:0] r_start_x, r_start_y, r_row_step_x, r_row_step_y;
    logic [AW-1:0] r_line_step_x, r_line_step_y;
    logic [arsr_pkg::HOLD_W-1:0] r_hold;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic                     r_s1_valid;
    arsr_pkg::t_pos           r_s1_pos;
    logic [SB-1:0]            r_s1_sy;

    logic                              r_o_valid;
    logic [arsr_pkg::COL_W-1:0]        r_o_col;
    logic [arsr_pkg::ROW_W-1:0]        r_o_row;
    logic [arsr_pkg::OUT_PEN_W-1:0]    r_o_pen;
    logic [arsr_pkg::PRIO_W-1:0]       r_o_prio;
    logic                              r_o_opaque;
    logic                              r_o_last;

    logic cfg_wr, advance, in_xfer, render, load;
    logic [ADDR_W-1:0]          scan_addr, ld_addr, mem_waddr;
    logic [SB-1:0]              scan_sy;
    arsr_pkg::t_pos             scan_pos;
    logic                       mem_we;
    logic [arsr_pkg::PEN_W-1:0] mem_wdata, mem_rdata;
    logic                       pix_opaque;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_row_step_x  <= '0;
            r_row_step_y  <= '0;
            r_line_step_x <= '0;
            r_line_step_y <= '0;
        end else if (cfg_wr) begin
            unique case (arsr_pkg::t_cfg_reg'(i_cfg_index))
                arsr_pkg::REG_START_X:     r_start_x     <= i_cfg_data;
                arsr_pkg::REG_START_Y:     r_start_y     <= i_cfg_data;
                arsr_pkg::REG_ROW_STEP_X:  r_row_step_x  <= i_cfg_data;
                arsr_pkg::REG_ROW_STEP_Y:  r_row_step_y  <= i_cfg_data;
                arsr_pkg::REG_LINE_STEP_X: r_line_step_x <= i_cfg_data;
                arsr_pkg::REG_LINE_STEP_Y: r_line_step_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (cfg_wr) begin
            r_hold <= arsr_pkg::CFG_SETTLE;
        end else if (r_hold != '0) begin
            r_hold <= r_hold - 1'b1;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign advance = !r_o_valid || i_ready;
    assign o_ready = !r_clearing && (r_hold == '0) && (!r_s1_valid || advance);
    assign in_xfer = i_valid && o_ready;
    assign render  = in_xfer && (i_cmd == arsr_pkg::CMD_RENDER);
    assign load    = in_xfer && (i_cmd == arsr_pkg::CMD_LOAD);

    assign ld_addr   = {SB'(i_src_row), SB'(i_src_col)};
    assign mem_we    = r_clearing || load;
    assign mem_waddr = r_clearing ? r_clr_addr : ld_addr;
    assign mem_wdata = r_clearing ? arsr_pkg::EMPTY_PEN : i_src_pen;

    arsr_scan_gen #(
        .OUT_WIDTH     (OUT_WIDTH),
        .OUT_HEIGHT    (OUT_HEIGHT),
        .SRC_SIDE_BITS (SRC_SIDE_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (render),
        .i_start_x     (r_start_x),
        .i_start_y     (r_start_y),
        .i_row_step_x  (r_row_step_x),
        .i_row_step_y  (r_row_step_y),
        .i_line_step_x (r_line_step_x),
        .i_line_step_y (r_line_step_y),
        .o_addr        (scan_addr),
        .o_sy          (scan_sy),
        .o_pos         (scan_pos)
    );

    arsr_frame_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (arsr_pkg::PEN_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (render),
        .i_raddr (scan_addr),
        .o_rdata (mem_rdata)
    );

    // read stage: waits for the frame-store data; read data holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (render) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (render) begin
            r_s1_pos <= scan_pos;
            r_s1_sy  <= scan_sy;
        end
    end

    assign pix_opaque = (mem_rdata != arsr_pkg::EMPTY_PEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_o_col    <= r_s1_pos.col;
            r_o_row    <= r_s1_pos.row;
            r_o_last   <= r_s1_pos.last;
            r_o_opaque <= pix_opaque;
            if (pix_opaque) begin
                // remap: pen bits 15, 13, 14 move to bits 9, 10, 11; bit 12 marks opaque
                r_o_pen  <= {1'b1, mem_rdata[14], mem_rdata[13], mem_rdata[15],
                             mem_rdata[8:0]};
                r_o_prio <= mem_rdata[15:8] | 8'h01;
            end else begin
                r_o_pen  <= arsr_pkg::OUT_PEN_W'(r_s1_sy);
                r_o_prio <= arsr_pkg::EMPTY_PRIO;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_col      = r_o_col;
    assign o_out_row      = r_o_row;
    assign o_out_pen      = r_o_pen;
    assign o_priority_res = r_o_prio;
    assign o_opaque       = r_o_opaque;
    assign o_frame_last   = r_o_last;

    `ARSR_ASSERT_NOW(a_clear_quiet, r_clearing, !r_s1_valid && !r_o_valid)
    `ARSR_ASSERT_NEXT(a_s1_held, r_s1_valid && r_o_valid && !i_ready, r_s1_valid)
    `ARSR_ASSERT_NEXT(a_cfg_settle, cfg_wr, !o_ready)
    `ARSR_ASSERT_NOW(a_last_corner, r_o_valid && r_o_last, (r_o_col == arsr_pkg::COL_W'(OUT_WIDTH - 1)) && (r_o_row == arsr_pkg::ROW_W'(OUT_HEIGHT - 1)))

endmodule

/* rtl/arsr_frame_mem.sv */
// Source frame store: one write port, one registered read port.
module arsr_frame_mem #(
    parameter int ADDR_W = 18,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/arsr_scan_gen.sv */
// Raster counters and affine accumulators; produces the frame-store read address.
module arsr_scan_gen #(
    parameter int OUT_WIDTH     = 320,
    parameter int OUT_HEIGHT    = 224,
    parameter int SRC_SIDE_BITS = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [arsr_pkg::ACC_W-1:0]      i_start_x,
    input  logic [arsr_pkg::ACC_W-1:0]      i_start_y,
    input  logic [arsr_pkg::ACC_W-1:0]      i_row_step_x,
    input  logic [arsr_pkg::ACC_W-1:0]      i_row_step_y,
    input  logic [arsr_pkg::ACC_W-1:0]      i_line_step_x,
    input  logic [arsr_pkg::ACC_W-1:0]      i_line_step_y,
    output logic [2*SRC_SIDE_BITS-1:0]      o_addr,
    output logic [SRC_SIDE_BITS-1:0]        o_sy,
    output arsr_pkg::t_pos                  o_pos
);

    localparam int AW = arsr_pkg::ACC_W;
    localparam int FB = arsr_pkg::FRAC_BITS;
    localparam logic [arsr_pkg::COL_W-1:0] COL_LAST  = arsr_pkg::COL_W'(OUT_WIDTH - 1);
    localparam logic [arsr_pkg::ROW_W-1:0] LINE_LAST = arsr_pkg::ROW_W'(OUT_HEIGHT - 1);

    logic [arsr_pkg::COL_W-1:0] r_col;
    logic [arsr_pkg::ROW_W-1:0] r_line;
    logic [AW-1:0] r_row_x, r_row_y, r_pix_x, r_pix_y;
    logic [AW-1:0] r_t16_x, r_t16_y, r_t3_x, r_t3_y;
    logic [AW-1:0] r_base_x, r_base_y;

    logic          frame_start, col_wrap;
    logic [AW-1:0] row_x, row_y, cur_x, cur_y;

    // start + 27 * row_step, split as 24*s and 3*s, registered as terms and then as the base
    always_ff @(posedge i_clk) begin
        r_t16_x  <= (i_row_step_x << 4) + (i_row_step_x << 3);
        r_t16_y  <= (i_row_step_y << 4) + (i_row_step_y << 3);
        r_t3_x   <= (i_row_step_x << 1) + i_row_step_x;
        r_t3_y   <= (i_row_step_y << 1) + i_row_step_y;
        r_base_x <= i_start_x + r_t16_x + r_t3_x;
        r_base_y <= i_start_y + r_t16_y + r_t3_y;
    end

    always_comb begin
        frame_start = (r_col == '0) && (r_line == '0);
        col_wrap    = (r_col == COL_LAST);
        row_x       = frame_start ? r_base_x : r_row_x;
        row_y       = frame_start ? r_base_y : r_row_y;
        cur_x       = (r_col == '0) ? row_x : r_pix_x;
        cur_y       = (r_col == '0) ? row_y : r_pix_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_pix_x <= cur_x + i_row_step_x;
            r_pix_y <= cur_y + i_row_step_y;
            r_row_x <= col_wrap ? row_x + i_line_step_x : row_x;
            r_row_y <= col_wrap ? row_y + i_line_step_y : row_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else if (i_step) begin
            if (col_wrap) begin
                r_col  <= '0;
                r_line <= (r_line == LINE_LAST) ? '0 : r_line + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    assign o_sy     = cur_y[FB+SRC_SIDE_BITS-1:FB];
    assign o_addr   = {cur_y[FB+SRC_SIDE_BITS-1:FB], cur_x[FB+SRC_SIDE_BITS-1:FB]};
    assign o_pos    = '{col: r_col, row: r_line, last: col_wrap && (r_line == LINE_LAST)};

endmodule

/* tb/sv/affine_rotate_scan_remap_test.sv */
// Self-checking testbench for the affine rotate-scan remapper, with its own pixel predictor.
module affine_rotate_scan_remap_test;

    localparam int OUT_W        = 320;
    localparam int OUT_H        = 224;
    localparam int SIDE_BITS    = 9;
    localparam int FRAME_DEPTH  = 1 << (2 * SIDE_BITS);
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 500;
    localparam int SWEEP_EXTRA  = 300;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int MAX_REPORTS  = 10;

    // register indexes past the last real register; writes there are dropped
    localparam logic [arsr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [arsr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } t_idle;
    typedef enum int {
        SET_ROTATE, SET_MAX, SET_MIN, SET_ONES, SET_ZERO, SET_RANDOM, SET_STEPS
    } t_setup;

    typedef struct packed {
        logic [arsr_pkg::COL_W-1:0]     col;
        logic [arsr_pkg::ROW_W-1:0]     row;
        logic [arsr_pkg::OUT_PEN_W-1:0] pen;
        logic [arsr_pkg::PRIO_W-1:0]    prio;
        logic                           opaque;
        logic                           last;
    } t_pixel;

    typedef struct packed {
        arsr_pkg::t_cmd             cmd;
        logic [8:0]                 col;
        logic [8:0]                 row;
        logic [arsr_pkg::PEN_W-1:0] pen;
        logic                       typed;
        t_pixel                     want;
    } t_vec;

    logic                                 i_clk          = 1'b0;
    logic                                 i_rst_n        = 1'b0;
    logic                                 i_cfg_valid    = 1'b0;
    logic                                 o_cfg_ready;
    logic [arsr_pkg::CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [arsr_pkg::ACC_W-1:0]           i_cfg_data     = '0;
    logic                                 i_valid        = 1'b0;
    logic                                 o_ready;
    logic                                 i_cmd          = 1'b0;
    logic [8:0]                           i_src_col      = '0;
    logic [8:0]                           i_src_row      = '0;
    logic [arsr_pkg::PEN_W-1:0]           i_src_pen      = '0;
    logic                                 o_valid;
    logic                                 i_ready        = 1'b0;
    logic [arsr_pkg::COL_W-1:0]           o_out_col;
    logic [arsr_pkg::ROW_W-1:0]           o_out_row;
    logic [arsr_pkg::OUT_PEN_W-1:0]       o_out_pen;
    logic [arsr_pkg::PRIO_W-1:0]          o_priority_res;
    logic                                 o_opaque;
    logic                                 o_frame_last;

    affine_rotate_scan_remap u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_src_col      (i_src_col),
        .i_src_row      (i_src_row),
        .i_src_pen      (i_src_pen),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_out_pen      (o_out_pen),
        .o_priority_res (o_priority_res),
        .o_opaque       (o_opaque),
        .o_frame_last   (o_frame_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [arsr_pkg::PEN_W-1:0] frame_pen [0:FRAME_DEPTH-1];
    logic [arsr_pkg::ACC_W-1:0] cfg_val [0:5];
    logic [arsr_pkg::ACC_W-1:0] row_x, row_y, cur_x, cur_y;
    logic [arsr_pkg::COL_W-1:0] scan_col;
    logic [arsr_pkg::ROW_W-1:0] scan_row;

    t_pixel pending_px [$];
    t_vec   dir_tab [0:16];

    int  send_pct   = 0;
    int  recv_pct   = 0;
    bit  hold_req   = 1'b0;
    int  hold_left  = 0;
    int  faults     = 0;
    int  items_in   = 0;
    int  pixels     = 0;
    int  opaque_n   = 0;
    int  wraps      = 0;
    int  cfg_writes = 0;
    longint cycles  = 0;

    // source coordinate that the next render will sample
    function automatic void next_sample(output logic [8:0] sx, output logic [8:0] sy);
        logic [arsr_pkg::ACC_W-1:0] ax, ay;
        ax = cur_x;
        ay = cur_y;
        if (scan_col == 0) begin
            ax = (scan_row == 0) ?
                cfg_val[arsr_pkg::REG_START_X] +
                32'd27 * cfg_val[arsr_pkg::REG_ROW_STEP_X] : row_x;
            ay = (scan_row == 0) ?
                cfg_val[arsr_pkg::REG_START_Y] +
                32'd27 * cfg_val[arsr_pkg::REG_ROW_STEP_Y] : row_y;
        end
        sx = ax[arsr_pkg::FRAC_BITS +: SIDE_BITS];
        sy = ay[arsr_pkg::FRAC_BITS +: SIDE_BITS];
    endfunction

    function automatic void scan_pixel(output t_pixel px);
        logic [8:0]                 sx, sy;
        logic [arsr_pkg::PEN_W-1:0] p;
        if (scan_col == 0) begin
            if (scan_row == 0) begin
                row_x = cfg_val[arsr_pkg::REG_START_X] +
                        32'd27 * cfg_val[arsr_pkg::REG_ROW_STEP_X];
                row_y = cfg_val[arsr_pkg::REG_START_Y] +
                        32'd27 * cfg_val[arsr_pkg::REG_ROW_STEP_Y];
            end
            cur_x = row_x;
            cur_y = row_y;
        end
        sx = cur_x[arsr_pkg::FRAC_BITS +: SIDE_BITS];
        sy = cur_y[arsr_pkg::FRAC_BITS +: SIDE_BITS];
        p = frame_pen[{sy, sx}];
        px.col = scan_col;
        px.row = scan_row;
        px.last = 1'b0;
        cur_x = cur_x + cfg_val[arsr_pkg::REG_ROW_STEP_X];
        cur_y = cur_y + cfg_val[arsr_pkg::REG_ROW_STEP_Y];
        if (scan_col == OUT_W - 1) begin
            scan_col = '0;
            row_x = row_x + cfg_val[arsr_pkg::REG_LINE_STEP_X];
            row_y = row_y + cfg_val[arsr_pkg::REG_LINE_STEP_Y];
            if (scan_row == OUT_H - 1) begin
                scan_row = '0;
                px.last = 1'b1;
            end else begin
                scan_row = scan_row + 1'b1;
            end
        end else begin
            scan_col = scan_col + 1'b1;
        end
        if (p != arsr_pkg::EMPTY_PEN) begin
            // bank bits 15 and 14:13 move down to 9 and 11:10
            px.pen = {1'b1, p[14:13], p[15], p[8:0]};
            px.prio = {p[15:9], 1'b1};
            px.opaque = 1'b1;
        end else begin
            px.pen = {4'b0, sy};
            px.prio = arsr_pkg::EMPTY_PRIO;
            px.opaque = 1'b0;
        end
    endfunction

    task automatic push_item(input arsr_pkg::t_cmd cmd, input logic [8:0] col,
                             input logic [8:0] row,
                             input logic [arsr_pkg::PEN_W-1:0] pen, input logic typed,
                             input t_pixel want);
        t_pixel px;
        while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_src_col <= col;
        i_src_row <= row;
        i_src_pen <= pen;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        items_in++;
        if (cmd == arsr_pkg::CMD_LOAD) begin
            frame_pen[{row, col}] = pen;
        end else begin
            scan_pixel(px);
            pending_px.push_back(typed ? want : px);
        end
    endtask

    task automatic write_reg(input logic [arsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arsr_pkg::ACC_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx <= arsr_pkg::REG_LINE_STEP_Y)
            cfg_val[idx] = data;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every pixel owed, then let any load still in flight land
    task automatic settle();
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setup(input t_setup setup);
        logic [arsr_pkg::ACC_W-1:0] v [0:5];
        for (int i = 0; i <= arsr_pkg::REG_LINE_STEP_Y; i++) begin
            case (setup)
                SET_MAX:   v[i] = 32'h7fff_ffff;
                SET_MIN:   v[i] = 32'h8000_0000;
                SET_ONES:  v[i] = 32'hffff_ffff;
                SET_ZERO:  v[i] = 32'h0000_0000;
                SET_STEPS: v[i] = 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
                default:   v[i] = $urandom;
            endcase
        end
        if (setup == SET_ROTATE) begin
            v[arsr_pkg::REG_ROW_STEP_X]  = 32'h0000_3800;
            v[arsr_pkg::REG_ROW_STEP_Y]  = 32'h0000_1000;
            v[arsr_pkg::REG_LINE_STEP_X] = 32'hffff_f000;
            v[arsr_pkg::REG_LINE_STEP_Y] = 32'h0000_3800;
        end
        for (int i = 0; i <= arsr_pkg::REG_LINE_STEP_Y; i++) begin
            // step-only setting keeps the old start point
            if (!(setup == SET_STEPS && i <= arsr_pkg::REG_START_Y))
                write_reg(arsr_pkg::CFG_IDX_W'(i), v[i]);
        end
        write_reg(CFG_IDX_SPARE_A, $urandom);
        write_reg(CFG_IDX_SPARE_B, $urandom);
    endtask

    task automatic gen_item(input bit render_bias, output arsr_pkg::t_cmd cmd,
                            output logic [8:0] col, output logic [8:0] row,
                            output logic [arsr_pkg::PEN_W-1:0] pen);
        logic [8:0] sx, sy;
        if (render_bias)
            cmd = ($urandom_range(0, 7) != 0) ? arsr_pkg::CMD_RENDER : arsr_pkg::CMD_LOAD;
        else
            cmd = ($urandom_range(0, 1) != 0) ? arsr_pkg::CMD_RENDER : arsr_pkg::CMD_LOAD;
        col = 9'($urandom_range(0, 511));
        row = 9'($urandom_range(0, 511));
        case ($urandom_range(0, 9))
            0:       pen = arsr_pkg::EMPTY_PEN;
            1:       pen = 16'h0000;
            2:       pen = 16'hfffe;
            default: pen = 16'($urandom);
        endcase
        // most loads land where the scan is about to read
        if (cmd == arsr_pkg::CMD_LOAD && $urandom_range(0, 9) < 6) begin
            next_sample(sx, sy);
            col = sx;
            row = sy;
        end
    endtask

    task automatic run_phase(input t_setup setup, input t_idle mode, input int count,
                             input bit squeeze, input bit sweep);
        arsr_pkg::t_cmd             cmd;
        logic [8:0]                 col, row;
        logic [arsr_pkg::PEN_W-1:0] pen;
        int                         left;
        settle();
        apply_setup(setup);
        send_pct = (mode == IDLE_SEND) ? 88 : (mode == IDLE_BOTH) ? 34 : 0;
        recv_pct = (mode == IDLE_RECV) ? 88 : (mode == IDLE_BOTH) ? 34 : 0;
        if (squeeze)
            hold_req = 1'b1;
        // a sweep runs the scan past the end of the frame and on into the next
        left = sweep ? (OUT_H - int'(scan_row)) * OUT_W - int'(scan_col) + SWEEP_EXTRA : count;
        while (left > 0) begin
            gen_item(sweep, cmd, col, row, pen);
            push_item(cmd, col, row, pen, 1'b0, '0);
            if (!sweep || cmd == arsr_pkg::CMD_RENDER)
                left--;
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    always @(posedge i_clk) begin : pixel_check
        t_pixel got, want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            got = '{o_out_col, o_out_row, o_out_pen, o_priority_res, o_opaque, o_frame_last};
            if (pending_px.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("unexpected pixel transfer: col %0d row %0d pen %h",
                             got.col, got.row, got.pen);
            end else begin
                want = pending_px.pop_front();
                pixels++;
                if (got.opaque) opaque_n++;
                if (got.last) wraps++;
                if (got.col !== want.col || got.row !== want.row || got.pen !== want.pen ||
                    got.prio !== want.prio || got.opaque !== want.opaque ||
                    got.last !== want.last) begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("pixel mismatch: want col %0d row %0d pen %h prio %h opq %b ",
                                 want.col, want.row, want.pen, want.prio, want.opaque,
                                 "last %b / got col %0d row %0d pen %h prio %h opq %b last %b",
                                 want.last, got.col, got.row, got.pen, got.prio, got.opaque,
                                 got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still owed", cycles,
                     pending_px.size());
            $display("affine_rotate_scan_remap_test NOT OK");
            $finish;
        end
    end

    initial begin
        for (int a = 0; a < FRAME_DEPTH; a++)
            frame_pen[a] = arsr_pkg::EMPTY_PEN;
        for (int r = 0; r <= arsr_pkg::REG_LINE_STEP_Y; r++)
            cfg_val[r] = '0;
        row_x = '0;
        row_y = '0;
        cur_x = '0;
        cur_y = '0;
        scan_col = '0;
        scan_row = '0;

        // zero steps after reset: every render samples source pixel (0,0)
        dir_tab[0]  = '{arsr_pkg::CMD_RENDER, 9'd0,   9'd0,   16'h0000, 1'b1,
                        '{9'd0, 8'd0, 13'h0000, 8'hff, 1'b0, 1'b0}};
        dir_tab[1]  = '{arsr_pkg::CMD_LOAD,   9'd0,   9'd0,   16'h0000, 1'b0, '0};
        dir_tab[2]  = '{arsr_pkg::CMD_RENDER, 9'd0,   9'd0,   16'h0000, 1'b1,
                        '{9'd1, 8'd0, 13'h1000, 8'h01, 1'b1, 1'b0}};
        dir_tab[3]  = '{arsr_pkg::CMD_LOAD,   9'd0,   9'd0,   16'hfffe, 1'b0, '0};
        dir_tab[4]  = '{arsr_pkg::CMD_RENDER, 9'd511, 9'd511, 16'hffff, 1'b1,
                        '{9'd2, 8'd0, 13'h1ffe, 8'hff, 1'b1, 1'b0}};
        dir_tab[5]  = '{arsr_pkg::CMD_LOAD,   9'd0,   9'd0,   16'hffff, 1'b0, '0};
        dir_tab[6]  = '{arsr_pkg::CMD_RENDER, 9'd0,   9'd0,   16'h0000, 1'b1,
                        '{9'd3, 8'd0, 13'h0000, 8'hff, 1'b0, 1'b0}};
        dir_tab[7]  = '{arsr_pkg::CMD_LOAD,   9'd511, 9'd511, 16'ha5a5, 1'b0, '0};
        dir_tab[8]  = '{arsr_pkg::CMD_LOAD,   9'd511, 9'd0,   16'h5a5a, 1'b0, '0};
        dir_tab[9]  = '{arsr_pkg::CMD_LOAD,   9'd0,   9'd511, 16'hc3c3, 1'b0, '0};
        dir_tab[10] = '{arsr_pkg::CMD_LOAD,   9'd0,   9'd0,   16'h7fff, 1'b0, '0};
        dir_tab[11] = '{arsr_pkg::CMD_RENDER, 9'd0,   9'd0,   16'h0000, 1'b1,
                        '{9'd4, 8'd0, 13'h1dff, 8'h7f, 1'b1, 1'b0}};
        dir_tab[12] = '{arsr_pkg::CMD_LOAD,   9'd0,   9'd0,   16'h8000, 1'b0, '0};
        dir_tab[13] = '{arsr_pkg::CMD_RENDER, 9'd0,   9'd0,   16'h0000, 1'b1,
                        '{9'd5, 8'd0, 13'h1200, 8'h81, 1'b1, 1'b0}};
        dir_tab[14] = '{arsr_pkg::CMD_LOAD,   9'd0,   9'd0,   16'h1234, 1'b0, '0};
        dir_tab[15] = '{arsr_pkg::CMD_RENDER, 9'd0,   9'd0,   16'h0000, 1'b1,
                        '{9'd6, 8'd0, 13'h1034, 8'h13, 1'b1, 1'b0}};
        dir_tab[16] = '{arsr_pkg::CMD_RENDER, 9'd0,   9'd0,   16'h0000, 1'b0, '0};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first transfer waits out the store clearing sweep
        foreach (dir_tab[k])
            push_item(dir_tab[k].cmd, dir_tab[k].col, dir_tab[k].row, dir_tab[k].pen,
                      dir_tab[k].typed, dir_tab[k].want);
        @(negedge i_clk);
        i_valid <= 1'b0;

        run_phase(SET_ROTATE, IDLE_NONE, 250, 1'b0, 1'b0);
        run_phase(SET_MAX,    IDLE_SEND, 200, 1'b0, 1'b0);
        run_phase(SET_MIN,    IDLE_RECV, 200, 1'b0, 1'b0);
        run_phase(SET_RANDOM, IDLE_BOTH, 250, 1'b0, 1'b0);
        run_phase(SET_STEPS,  IDLE_NONE, 200, 1'b1, 1'b0);
        run_phase(SET_ONES,   IDLE_BOTH, 150, 1'b0, 1'b0);
        run_phase(SET_ZERO,   IDLE_RECV, 150, 1'b0, 1'b0);
        run_phase(SET_ROTATE, IDLE_NONE, 100, 1'b0, 1'b0);
        run_phase(SET_RANDOM, IDLE_SEND, 200, 1'b0, 1'b0);
        run_phase(SET_STEPS,  IDLE_NONE, 200, 1'b0, 1'b0);
        settle();

        $display("covered %0d items in, %0d pixels compared (%0d opaque), %0d frame wraps",
                 items_in, pixels, opaque_n, wraps);
        $display("%0d register writes over extreme, rotated and random settings; %0d faults",
                 cfg_writes, faults);
        if (faults == 0)
            $display("affine_rotate_scan_remap_test OK");
        else
            $display("affine_rotate_scan_remap_test NOT OK");
        $finish;
    end

endmodule

/* affine_rotate_scan_remap.f */
+incdir+rtl
rtl/arsr_pkg.sv
rtl/arsr_frame_mem.sv
rtl/arsr_scan_gen.sv
rtl/affine_rotate_scan_remap.sv
tb/sv/affine_rotate_scan_remap_test.sv
